FILE: rtl/core/wavhdr_pkg.sv
// ----------------------------------------------------------------------------
// wavhdr_pkg
// Types and constants shared by the WAV header parser files.
// ----------------------------------------------------------------------------
package wavhdr_pkg;

    typedef enum logic [2:0] {
        PH_RIFF  = 3'd0,
        PH_WAVE  = 3'd1,
        PH_CHUNK = 3'd2,
        PH_FMT   = 3'd3,
        PH_SKIP  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_RIFF   = 3'd1,
        ST_NOT_WAVE   = 3'd2,
        ST_SHORT_FMT  = 3'd3,
        ST_NO_FMT     = 3'd4,
        ST_NO_DATA    = 3'd5,
        ST_BAD_FORMAT = 3'd6,
        ST_NOT_ST16   = 3'd7
    } status_t;

    typedef struct packed {
        logic [31:0] payload_length;
        logic [31:0] payload_offset;
        logic [15:0] sample_bits;
        logic [31:0] sample_rate_hz;
        logic [15:0] channel_count;
        logic [15:0] format_tag;
        status_t     status;
    } result_t;

    // chunk ids, big-endian as they arrive
    localparam logic [31:0] ID_RIFF = 32'h5249_4646;
    localparam logic [31:0] ID_WAVE = 32'h5741_5645;
    localparam logic [31:0] ID_FMT  = 32'h666D_7420;
    localparam logic [31:0] ID_DATA = 32'h6461_7461;

    localparam logic [15:0] FMT_PCM      = 16'h0001;
    localparam logic [15:0] FMT_EXT      = 16'hFFFE;
    localparam logic [15:0] STEREO_CHANS = 16'd2;
    localparam logic [15:0] PCM16_BITS   = 16'd16;

endpackage

FILE: rtl/core/wavhdr_parser.sv
// ----------------------------------------------------------------------------
// wavhdr_parser
// Parse state and per-byte update; flags the byte that completes a result.
// ----------------------------------------------------------------------------
module wavhdr_parser #(
    parameter int FMT_READ_MAX = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [7:0]          file_byte,
    input  logic                first_byte,
    input  logic                last_byte,
    output logic                res_valid,
    output wavhdr_pkg::result_t res
);

    localparam int FW = $clog2(FMT_READ_MAX + 1);
    localparam logic [FW-1:0] READ_MAX = FW'(FMT_READ_MAX);

    wavhdr_pkg::phase_t phase_reg, phase_next, cur_phase;
    logic [FW-1:0] idx_reg, idx_next, cur_idx, idx_inc;
    logic [FW-1:0] flen_reg, flen_next, cur_flen, rd_len;
    logic [63:0]   shift_reg, shift_next, cur_shift, shift_new;
    logic [31:0]   skip_reg, skip_next, cur_skip, skip_dec, body_skip;
    logic [31:0]   pos_reg, pos_next, cur_pos, pos_inc;
    logic          seen_fmt_reg, seen_fmt_next, cur_seen_fmt;
    logic          seen_data_reg, seen_data_next, cur_seen_data;
    logic          fin_reg, fin_next, cur_fin;
    logic [15:0]   fmt_reg, fmt_next, cur_fmt;
    logic [15:0]   chan_reg, chan_next, cur_chan;
    logic [31:0]   rate_reg, rate_next, cur_rate;
    logic [15:0]   bits_reg, bits_next, cur_bits;
    logic [31:0]   offset_reg, offset_next, cur_offset;
    logic [31:0]   length_reg, length_next, cur_length;

    logic          active, hdr_done, wave_done, fmt_done, is_fmt, is_data, size_lt;
    logic [31:0]   chunk_size;
    logic          emit;
    wavhdr_pkg::status_t status;

    // first_byte restarts the file before the byte itself is taken
    assign cur_phase     = first_byte ? wavhdr_pkg::PH_RIFF : phase_reg;
    assign cur_idx       = first_byte ? '0 : idx_reg;
    assign cur_flen      = first_byte ? '0 : flen_reg;
    assign cur_shift     = first_byte ? '0 : shift_reg;
    assign cur_skip      = first_byte ? '0 : skip_reg;
    assign cur_pos       = first_byte ? '0 : pos_reg;
    assign cur_seen_fmt  = first_byte ? 1'b0 : seen_fmt_reg;
    assign cur_seen_data = first_byte ? 1'b0 : seen_data_reg;
    assign cur_fin       = first_byte ? 1'b0 : fin_reg;
    assign cur_fmt       = first_byte ? '0 : fmt_reg;
    assign cur_chan      = first_byte ? '0 : chan_reg;
    assign cur_rate      = first_byte ? '0 : rate_reg;
    assign cur_bits      = first_byte ? '0 : bits_reg;
    assign cur_offset    = first_byte ? '0 : offset_reg;
    assign cur_length    = first_byte ? '0 : length_reg;

    assign active     = in_valid && !cur_fin;
    assign shift_new  = {cur_shift[55:0], file_byte};
    assign idx_inc    = cur_idx + FW'(1);
    assign hdr_done   = (idx_inc == FW'(8));
    assign wave_done  = (idx_inc == FW'(4));
    assign fmt_done   = (idx_inc >= cur_flen);
    assign chunk_size = {shift_new[7:0], shift_new[15:8], shift_new[23:16], shift_new[31:24]};
    assign is_fmt     = (shift_new[63:32] == wavhdr_pkg::ID_FMT);
    assign is_data    = (shift_new[63:32] == wavhdr_pkg::ID_DATA);
    assign size_lt    = (chunk_size < 32'(FMT_READ_MAX));
    assign rd_len     = size_lt ? chunk_size[FW-1:0] : READ_MAX;
    assign body_skip  = is_fmt ? (chunk_size - 32'(rd_len)) : chunk_size;
    assign skip_dec   = (cur_skip != 32'd0) ? (cur_skip - 32'd1) : cur_skip;
    assign pos_inc    = (cur_pos == 32'hFFFF_FFFF) ? cur_pos : (cur_pos + 32'd1);

    // next phase
    always_comb
    begin
        phase_next = cur_phase;
        if (active)
        begin
            case (cur_phase)
                wavhdr_pkg::PH_RIFF:
                begin
                    if (hdr_done && shift_new[63:32] == wavhdr_pkg::ID_RIFF)
                        phase_next = wavhdr_pkg::PH_WAVE;
                end
                wavhdr_pkg::PH_WAVE:
                begin
                    if (wave_done && shift_new[31:0] == wavhdr_pkg::ID_WAVE)
                        phase_next = wavhdr_pkg::PH_CHUNK;
                end
                wavhdr_pkg::PH_CHUNK:
                begin
                    if (hdr_done)
                    begin
                        if (is_fmt && rd_len != '0)
                            phase_next = wavhdr_pkg::PH_FMT;
                        else if (body_skip != 32'd0)
                            phase_next = wavhdr_pkg::PH_SKIP;
                        else
                            phase_next = wavhdr_pkg::PH_CHUNK;
                    end
                end
                wavhdr_pkg::PH_FMT:
                begin
                    if (fmt_done)
                        phase_next = (cur_skip != 32'd0) ? wavhdr_pkg::PH_SKIP
                                                         : wavhdr_pkg::PH_CHUNK;
                end
                wavhdr_pkg::PH_SKIP:
                begin
                    if (skip_dec == 32'd0)
                        phase_next = wavhdr_pkg::PH_CHUNK;
                end
                default:
                    phase_next = wavhdr_pkg::PH_RIFF;
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        logic bad_riff;
        logic bad_wave;
        bad_riff       = 1'b0;
        bad_wave       = 1'b0;
        idx_next       = cur_idx;
        flen_next      = cur_flen;
        shift_next     = cur_shift;
        skip_next      = cur_skip;
        pos_next       = cur_pos;
        seen_fmt_next  = cur_seen_fmt;
        seen_data_next = cur_seen_data;
        fmt_next       = cur_fmt;
        chan_next      = cur_chan;
        rate_next      = cur_rate;
        bits_next      = cur_bits;
        offset_next    = cur_offset;
        length_next    = cur_length;
        emit           = 1'b0;
        status         = wavhdr_pkg::ST_OK;

        if (active)
        begin
            pos_next = pos_inc;
            case (cur_phase)
                wavhdr_pkg::PH_RIFF:
                begin
                    shift_next = shift_new;
                    idx_next   = hdr_done ? '0 : idx_inc;
                    bad_riff   = hdr_done && (shift_new[63:32] != wavhdr_pkg::ID_RIFF);
                end
                wavhdr_pkg::PH_WAVE:
                begin
                    shift_next = shift_new;
                    idx_next   = wave_done ? '0 : idx_inc;
                    bad_wave   = wave_done && (shift_new[31:0] != wavhdr_pkg::ID_WAVE);
                end
                wavhdr_pkg::PH_CHUNK:
                begin
                    shift_next = shift_new;
                    idx_next   = hdr_done ? '0 : idx_inc;
                    if (hdr_done)
                    begin
                        skip_next = body_skip;
                        if (is_fmt)
                        begin
                            fmt_next  = '0;
                            chan_next = '0;
                            rate_next = '0;
                            bits_next = '0;
                            flen_next = rd_len;
                            if (rd_len == '0)
                                seen_fmt_next = 1'b1;
                        end
                        else if (is_data)
                        begin
                            offset_next    = pos_inc;
                            length_next    = chunk_size;
                            seen_data_next = 1'b1;
                        end
                    end
                end
                wavhdr_pkg::PH_FMT:
                begin
                    // body bytes 0..7 and 14..15 carry the fields we keep
                    if (cur_idx < FW'(2))
                        fmt_next[8*cur_idx[0] +: 8] = file_byte;
                    else if (cur_idx < FW'(4))
                        chan_next[8*cur_idx[0] +: 8] = file_byte;
                    else if (cur_idx < FW'(8))
                        rate_next[8*cur_idx[1:0] +: 8] = file_byte;
                    else if (cur_idx == FW'(14) || cur_idx == FW'(15))
                        bits_next[8*cur_idx[0] +: 8] = file_byte;
                    idx_next = fmt_done ? '0 : idx_inc;
                    if (fmt_done)
                        seen_fmt_next = 1'b1;
                end
                wavhdr_pkg::PH_SKIP:
                    skip_next = skip_dec;
                default:
                    idx_next = '0;
            endcase

            if (bad_riff)
            begin
                emit   = 1'b1;
                status = wavhdr_pkg::ST_NOT_RIFF;
            end
            else if (bad_wave)
            begin
                emit   = 1'b1;
                status = wavhdr_pkg::ST_NOT_WAVE;
            end
            else if (seen_fmt_next && seen_data_next)
            begin
                emit = 1'b1;
                if (fmt_next != wavhdr_pkg::FMT_PCM && fmt_next != wavhdr_pkg::FMT_EXT)
                    status = wavhdr_pkg::ST_BAD_FORMAT;
                else if (chan_next != wavhdr_pkg::STEREO_CHANS
                         || bits_next != wavhdr_pkg::PCM16_BITS)
                    status = wavhdr_pkg::ST_NOT_ST16;
                else
                    status = wavhdr_pkg::ST_OK;
            end
            else if (last_byte)
            begin
                emit = 1'b1;
                case (phase_next)
                    wavhdr_pkg::PH_RIFF: status = wavhdr_pkg::ST_NOT_RIFF;
                    wavhdr_pkg::PH_WAVE: status = wavhdr_pkg::ST_NOT_WAVE;
                    wavhdr_pkg::PH_FMT:  status = wavhdr_pkg::ST_SHORT_FMT;
                    default:
                        status = seen_fmt_next ? wavhdr_pkg::ST_NO_DATA
                                               : wavhdr_pkg::ST_NO_FMT;
                endcase
            end
        end
    end

    assign fin_next  = cur_fin || emit;
    assign res_valid = emit;

    assign res.status         = status;
    assign res.format_tag     = fmt_next;
    assign res.channel_count  = chan_next;
    assign res.sample_rate_hz = rate_next;
    assign res.sample_bits    = bits_next;
    assign res.payload_offset = offset_next;
    assign res.payload_length = length_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= wavhdr_pkg::PH_RIFF;
            idx_reg       <= '0;
            flen_reg      <= '0;
            shift_reg     <= '0;
            skip_reg      <= '0;
            pos_reg       <= '0;
            seen_fmt_reg  <= 1'b0;
            seen_data_reg <= 1'b0;
            fin_reg       <= 1'b0;
            fmt_reg       <= '0;
            chan_reg      <= '0;
            rate_reg      <= '0;
            bits_reg      <= '0;
            offset_reg    <= '0;
            length_reg    <= '0;
        end
        else if (in_valid)
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            flen_reg      <= flen_next;
            shift_reg     <= shift_next;
            skip_reg      <= skip_next;
            pos_reg       <= pos_next;
            seen_fmt_reg  <= seen_fmt_next;
            seen_data_reg <= seen_data_next;
            fin_reg       <= fin_next;
            fmt_reg       <= fmt_next;
            chan_reg      <= chan_next;
            rate_reg      <= rate_next;
            bits_reg      <= bits_next;
            offset_reg    <= offset_next;
            length_reg    <= length_next;
        end
    end

endmodule

FILE: rtl/core/wav_riff_header_parser.sv
// ----------------------------------------------------------------------------
// wav_riff_header_parser
// Byte-stream WAV header parser with a registered result stream.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle (s_tuser marks the first byte of a file,
// s_tlast the last) and returns at most one result per file on the m_ side,
// in the cycle after the byte that decides it: both fmt and data chunks seen, a
// bad id, or end of file. Every byte is handled by a single pass through the
// parse state, so the input sustains one transfer per clock; it stalls only
// while a result sits in the output register and m_tready is low. Bytes
// after the result are taken and dropped until the next first byte.
module wav_riff_header_parser #(
    parameter int FMT_READ_MAX = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // file_byte
    input  logic         s_tuser,   // first_byte
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], format_tag[18:3], channel_count[34:19],
    // sample_rate_hz[66:35], sample_bits[82:67], payload_offset[114:83],
    // payload_length[146:115], zero fill[151:147]
    output logic [151:0] m_tdata
);

    logic                m_tvalid_reg;
    wavhdr_pkg::result_t res_reg;
    wavhdr_pkg::result_t res;
    logic                res_valid;
    logic                accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    wavhdr_parser #(
        .FMT_READ_MAX (FMT_READ_MAX)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .file_byte  (s_tdata),
        .first_byte (s_tuser),
        .last_byte  (s_tlast),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (accept && res_valid)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
            res_reg <= res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, res_reg};

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the WAV RIFF header parser. Byte streams that build
// well-formed, damaged and truncated WAV files are driven into the slave side;
// a byte-level model of the parser predicts each result, and every transfer
// on the master side is checked against it field by field.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FMT_TAKE_MAX = 64;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [7:0] value;
        logic       is_first;
        logic       is_last;
    } file_byte_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;  // file_byte
    logic         s_tuser = 1'b0;   // first_byte
    logic         s_tlast = 1'b0;   // last_byte
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // status, format_tag, channel_count, sample_rate_hz, sample_bits,
    // payload_offset, payload_length, zero fill
    logic [151:0] m_tdata;

    wav_riff_header_parser #(
        .FMT_READ_MAX(FMT_TAKE_MAX)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    file_byte_t          pending_bytes[$];
    logic [7:0]          file_bytes[$];
    wavhdr_pkg::result_t expected_reports[$];
    int                  queued_items = 0;
    int                  fail_count = 0;
    int                  cycle_count = 0;
    int                  send_gap_pct = 0;
    int                  recv_stall_pct = 0;
    logic                byte_taken = 1'b0;

    // ---------------- parser model state ----------------
    wavhdr_pkg::phase_t parse_ph;
    int unsigned        hdr_count;
    logic [63:0]        hdr_bytes;
    logic [31:0]        body_left;
    int unsigned        fmt_take;
    logic [31:0]        file_pos;
    bit                 fmt_seen;
    bit                 data_seen;
    bit                 reported;
    logic [15:0]        cap_format;
    logic [15:0]        cap_chans;
    logic [31:0]        cap_rate;
    logic [15:0]        cap_bits;
    logic [31:0]        cap_offset;
    logic [31:0]        cap_length;

    function automatic void clear_parse();
        parse_ph   = wavhdr_pkg::PH_RIFF;
        hdr_count  = 0;
        hdr_bytes  = '0;
        body_left  = '0;
        fmt_take   = 0;
        file_pos   = '0;
        fmt_seen   = 1'b0;
        data_seen  = 1'b0;
        reported   = 1'b0;
        cap_format = '0;
        cap_chans  = '0;
        cap_rate   = '0;
        cap_bits   = '0;
        cap_offset = '0;
        cap_length = '0;
    endfunction

    function automatic wavhdr_pkg::phase_t body_phase();
        if (body_left != 0)
            return wavhdr_pkg::PH_SKIP;
        return wavhdr_pkg::PH_CHUNK;
    endfunction

    // Advances the model by one file byte; returns 1 when the byte yields a result.
    function automatic bit parse_wav_byte(input logic [7:0] b, input bit first, input bit last,
                                          output wavhdr_pkg::result_t rep);
        logic [31:0]         id;
        logic [31:0]         size;
        logic [31:0]         n;
        bit                  hit;
        wavhdr_pkg::status_t st;
        hit = 1'b0;
        st  = wavhdr_pkg::ST_OK;
        rep = '0;
        if (first)
            clear_parse();
        if (reported)
            return 1'b0;
        if (file_pos != 32'hFFFF_FFFF)
            file_pos++;

        case (parse_ph)
            wavhdr_pkg::PH_RIFF:
            begin
                hdr_bytes = {hdr_bytes[55:0], b};
                hdr_count++;
                if (hdr_count >= 8)
                begin
                    hdr_count = 0;
                    if (hdr_bytes[63:32] != wavhdr_pkg::ID_RIFF)
                    begin
                        hit = 1'b1;
                        st  = wavhdr_pkg::ST_NOT_RIFF;
                    end
                    else
                        parse_ph = wavhdr_pkg::PH_WAVE;
                end
            end
            wavhdr_pkg::PH_WAVE:
            begin
                hdr_bytes = {hdr_bytes[55:0], b};
                hdr_count++;
                if (hdr_count >= 4)
                begin
                    hdr_count = 0;
                    if (hdr_bytes[31:0] != wavhdr_pkg::ID_WAVE)
                    begin
                        hit = 1'b1;
                        st  = wavhdr_pkg::ST_NOT_WAVE;
                    end
                    else
                        parse_ph = wavhdr_pkg::PH_CHUNK;
                end
            end
            wavhdr_pkg::PH_CHUNK:
            begin
                hdr_bytes = {hdr_bytes[55:0], b};
                hdr_count++;
                if (hdr_count >= 8)
                begin
                    id   = hdr_bytes[63:32];
                    // size field is little-endian, first byte arrived earliest
                    size = {hdr_bytes[7:0], hdr_bytes[15:8], hdr_bytes[23:16], hdr_bytes[31:24]};
                    hdr_count = 0;
                    if (id == wavhdr_pkg::ID_FMT)
                    begin
                        n = (size < 32'(FMT_TAKE_MAX)) ? size : 32'(FMT_TAKE_MAX);
                        cap_format = '0;
                        cap_chans  = '0;
                        cap_rate   = '0;
                        cap_bits   = '0;
                        fmt_take   = 32'(n[6:0]);
                        body_left  = size - n;
                        if (n != 0)
                            parse_ph = wavhdr_pkg::PH_FMT;
                        else
                        begin
                            fmt_seen = 1'b1;
                            parse_ph = body_phase();
                        end
                    end
                    else if (id == wavhdr_pkg::ID_DATA)
                    begin
                        cap_offset = file_pos;
                        cap_length = size;
                        data_seen  = 1'b1;
                        body_left  = size;
                        parse_ph   = body_phase();
                    end
                    else
                    begin
                        body_left = size;
                        parse_ph  = body_phase();
                    end
                end
            end
            wavhdr_pkg::PH_FMT:
            begin
                if (hdr_count < 2)
                    cap_format |= 16'(b) << (8 * hdr_count);
                else if (hdr_count < 4)
                    cap_chans |= 16'(b) << (8 * (hdr_count - 2));
                else if (hdr_count < 8)
                    cap_rate |= 32'(b) << (8 * (hdr_count - 4));
                else if (hdr_count == 14 || hdr_count == 15)
                    cap_bits |= 16'(b) << (8 * (hdr_count - 14));
                hdr_count++;
                if (hdr_count >= fmt_take)
                begin
                    hdr_count = 0;
                    fmt_seen  = 1'b1;
                    parse_ph  = body_phase();
                end
            end
            default:
            begin
                if (body_left != 0)
                    body_left--;
                if (body_left == 0)
                    parse_ph = wavhdr_pkg::PH_CHUNK;
            end
        endcase

        if (!hit && fmt_seen && data_seen)
        begin
            hit = 1'b1;
            if (!(cap_format == wavhdr_pkg::FMT_PCM || cap_format == wavhdr_pkg::FMT_EXT))
                st = wavhdr_pkg::ST_BAD_FORMAT;
            else if (cap_chans != wavhdr_pkg::STEREO_CHANS
                     || cap_bits != wavhdr_pkg::PCM16_BITS)
                st = wavhdr_pkg::ST_NOT_ST16;
            else
                st = wavhdr_pkg::ST_OK;
        end
        else if (!hit && last)
        begin
            hit = 1'b1;
            if (parse_ph == wavhdr_pkg::PH_RIFF)
                st = wavhdr_pkg::ST_NOT_RIFF;
            else if (parse_ph == wavhdr_pkg::PH_WAVE)
                st = wavhdr_pkg::ST_NOT_WAVE;
            else if (parse_ph == wavhdr_pkg::PH_FMT)
                st = wavhdr_pkg::ST_SHORT_FMT;
            else if (fmt_seen)
                st = wavhdr_pkg::ST_NO_DATA;
            else
                st = wavhdr_pkg::ST_NO_FMT;
        end

        if (hit)
        begin
            reported           = 1'b1;
            rep.status         = st;
            rep.format_tag     = cap_format;
            rep.channel_count  = cap_chans;
            rep.sample_rate_hz = cap_rate;
            rep.sample_bits    = cap_bits;
            rep.payload_offset = cap_offset;
            rep.payload_length = cap_length;
        end
        return hit;
    endfunction

    // ---------------- file construction ----------------
    task automatic queue_byte(input logic [7:0] b, input bit first, input bit last);
        file_byte_t fb;
        fb.value    = b;
        fb.is_first = first;
        fb.is_last  = last;
        pending_bytes.push_back(fb);
    endtask

    task automatic put_byte(input logic [7:0] b);
        file_bytes.push_back(b);
    endtask

    task automatic put_le32(input logic [31:0] v);
        put_byte(v[7:0]);
        put_byte(v[15:8]);
        put_byte(v[23:16]);
        put_byte(v[31:24]);
    endtask

    // ids go out big-endian, as they read in the file
    task automatic put_id(input logic [31:0] id);
        put_byte(id[31:24]);
        put_byte(id[23:16]);
        put_byte(id[15:8]);
        put_byte(id[7:0]);
    endtask

    // early_data: data chunks placed ahead of the fmt chunk (0 puts one after it)
    task automatic build_file(input logic [31:0] fmt_len, input logic [15:0] tag,
                              input logic [15:0] chans, input logic [15:0] bits,
                              input int early_data, input int junk_len,
                              input logic [31:0] data_len, input bit extra_fmt);
        int body;
        file_bytes.delete();
        put_id(wavhdr_pkg::ID_RIFF);
        put_le32($urandom);
        put_id(wavhdr_pkg::ID_WAVE);
        if (junk_len >= 0)
        begin
            put_id($urandom);
            put_le32(junk_len);
            repeat (junk_len) put_byte(8'($urandom));
        end
        if (extra_fmt)
        begin
            put_id(wavhdr_pkg::ID_FMT);
            put_le32(32'd16);
            repeat (16) put_byte(8'($urandom));
        end
        repeat (early_data)
        begin
            put_id(wavhdr_pkg::ID_DATA);
            put_le32(data_len);
            repeat (data_len) put_byte(8'($urandom));
        end
        put_id(wavhdr_pkg::ID_FMT);
        put_le32(fmt_len);
        body = (fmt_len > 100) ? 100 : int'(fmt_len);
        for (int i = 0; i < body; i++)
        begin
            case (i)
                0:       put_byte(tag[7:0]);
                1:       put_byte(tag[15:8]);
                2:       put_byte(chans[7:0]);
                3:       put_byte(chans[15:8]);
                14:      put_byte(bits[7:0]);
                15:      put_byte(bits[15:8]);
                default: put_byte(8'($urandom));
            endcase
        end
        if (early_data == 0)
        begin
            put_id(wavhdr_pkg::ID_DATA);
            put_le32(data_len);
            repeat ($urandom_range(3)) put_byte(8'($urandom));
        end
    endtask

    // cut > 0 truncates the file there and flags the final byte as the end
    task automatic send_file(input int cut, input bit mark_last);
        int n;
        n = (cut > 0 && cut < file_bytes.size()) ? cut : file_bytes.size();
        for (int i = 0; i < n; i++)
            queue_byte(file_bytes[i], i == 0, (i == n - 1) && (cut > 0 || mark_last));
        queued_items += n;
        if (cut <= 0 && !mark_last)
            repeat ($urandom_range(4)) queue_byte(8'($urandom), 1'b0, $urandom_range(3) == 0);
    endtask

    task automatic random_files(input int target);
        int          start;
        int          pick;
        int          n;
        int          k;
        int          early;
        int          junk;
        logic [31:0] flen;
        logic [31:0] dlen;
        logic [15:0] tag;
        logic [15:0] chans;
        logic [15:0] bits;
        start = queued_items;
        while (queued_items - start < target)
        begin
            if ($urandom_range(99) < 8)
            begin
                // raw noise with stray first/last flags
                n = $urandom_range(1, 24);
                repeat (n)
                    queue_byte(8'($urandom), $urandom_range(9) == 0, $urandom_range(9) == 0);
                queued_items += n;
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 50)
                    flen = 16;
                else if (pick < 60)
                    flen = 18;
                else if (pick < 68)
                    flen = 40;
                else if (pick < 76)
                    flen = $urandom_range(15);
                else if (pick < 84)
                    flen = FMT_TAKE_MAX;
                else if (pick < 96)
                    flen = $urandom_range(FMT_TAKE_MAX + 1, 100);
                else
                    flen = $urandom;
                pick = $urandom_range(99);
                tag = (pick < 70) ? wavhdr_pkg::FMT_PCM :
                      (pick < 85) ? wavhdr_pkg::FMT_EXT : 16'($urandom);
                chans = ($urandom_range(99) < 80) ? wavhdr_pkg::STEREO_CHANS :
                        ($urandom_range(1) ? 16'($urandom) : 16'($urandom_range(8)));
                bits = ($urandom_range(99) < 80) ? wavhdr_pkg::PCM16_BITS :
                       ($urandom_range(1) ? 16'($urandom) : 16'(8 * $urandom_range(1, 4)));
                pick  = $urandom_range(99);
                early = (pick < 25) ? 1 : (pick < 32) ? 2 : 0;
                junk  = ($urandom_range(99) < 30) ? $urandom_range(6) : -1;
                dlen  = (early != 0) ? $urandom_range(8) : $urandom;
                build_file(flen, tag, chans, bits, early, junk, dlen, $urandom_range(9) == 0);
                if ($urandom_range(99) < 6)
                begin
                    k = $urandom_range(1) ? $urandom_range(11) : $urandom_range(file_bytes.size() - 1);
                    file_bytes[k] ^= 8'(1 << $urandom_range(7));
                end
                if ($urandom_range(99) < 25)
                    send_file($urandom_range(1, file_bytes.size()), 1'b1);
                else
                    send_file(0, $urandom_range(1));
            end
        end
    endtask

    task automatic directed_files();
        build_file(16, wavhdr_pkg::FMT_PCM, wavhdr_pkg::STEREO_CHANS, wavhdr_pkg::PCM16_BITS,
                   0, -1, 1000, 1'b0);
        send_file(0, 1'b1);
        // extensible tag, empty junk chunk, maximum data size, trailing bytes
        build_file(40, wavhdr_pkg::FMT_EXT, wavhdr_pkg::STEREO_CHANS, wavhdr_pkg::PCM16_BITS,
                   0, 0, 32'hFFFF_FFFF, 1'b0);
        send_file(0, 1'b0);
        build_file(16, 16'h0003, wavhdr_pkg::STEREO_CHANS, wavhdr_pkg::PCM16_BITS,
                   0, -1, 8, 1'b0);
        send_file(0, 1'b1);
        build_file(16, wavhdr_pkg::FMT_PCM, 16'd1, wavhdr_pkg::PCM16_BITS, 0, -1, 8, 1'b0);
        send_file(0, 1'b1);
        // data ahead of fmt: decided when the fmt capture completes
        build_file(18, wavhdr_pkg::FMT_PCM, wavhdr_pkg::STEREO_CHANS, 16'd24, 1, 5, 3, 1'b0);
        send_file(0, 1'b1);
        // empty fmt body: decided at the fmt header, all captures zero
        build_file(0, wavhdr_pkg::FMT_PCM, wavhdr_pkg::STEREO_CHANS, wavhdr_pkg::PCM16_BITS,
                   1, -1, 2, 1'b0);
        send_file(0, 1'b1);
        // fmt body too short to hold the bits field
        build_file(10, wavhdr_pkg::FMT_PCM, wavhdr_pkg::STEREO_CHANS, wavhdr_pkg::PCM16_BITS,
                   0, -1, 4, 1'b0);
        send_file(0, 1'b1);
        // fmt body beyond the capture window, repeated fmt chunk
        build_file(100, wavhdr_pkg::FMT_PCM, wavhdr_pkg::STEREO_CHANS, wavhdr_pkg::PCM16_BITS,
                   0, -1, 4, 1'b1);
        send_file(0, 1'b1);
        // two data chunks, the later one wins
        build_file(16, wavhdr_pkg::FMT_EXT, wavhdr_pkg::STEREO_CHANS, wavhdr_pkg::PCM16_BITS,
                   2, -1, 6, 1'b0);
        send_file(0, 1'b0);
        build_file(16, wavhdr_pkg::FMT_PCM, wavhdr_pkg::STEREO_CHANS, wavhdr_pkg::PCM16_BITS,
                   0, -1, 8, 1'b0);
        file_bytes[0] ^= 8'h01;
        send_file(0, 1'b1);
        build_file(16, wavhdr_pkg::FMT_PCM, wavhdr_pkg::STEREO_CHANS, wavhdr_pkg::PCM16_BITS,
                   0, -1, 8, 1'b0);
        file_bytes[11] ^= 8'h80;
        send_file(0, 1'b1);
        // truncations: RIFF header, WAVE id, fmt capture, capture ending on
        // the final byte, chunk header with no fmt, after a data payload
        build_file(16, wavhdr_pkg::FMT_PCM, wavhdr_pkg::STEREO_CHANS, wavhdr_pkg::PCM16_BITS,
                   0, -1, 8, 1'b0);
        send_file(3, 1'b1);
        send_file(10, 1'b1);
        send_file(25, 1'b1);
        send_file(36, 1'b1);
        send_file(14, 1'b1);
        build_file(16, wavhdr_pkg::FMT_PCM, wavhdr_pkg::STEREO_CHANS, wavhdr_pkg::PCM16_BITS,
                   1, -1, 2, 1'b0);
        send_file(22, 1'b1);
    endtask

    // ---------------- driver ----------------
    always @(negedge clk)
    begin
        file_byte_t nxt;
        if (rst_n)
        begin
            if (!s_tvalid || byte_taken)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    nxt = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.value;
                    s_tuser  <= nxt.is_first;
                    s_tlast  <= nxt.is_last;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------- monitor and checks ----------------
    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        wavhdr_pkg::result_t rep;
        wavhdr_pkg::result_t got;
        wavhdr_pkg::result_t want;
        byte_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (parse_wav_byte(s_tdata, s_tuser, s_tlast, rep))
                    expected_reports.push_back(rep);
            end
            if (m_tvalid && m_tready)
            begin
                got = wavhdr_pkg::result_t'(m_tdata[146:0]);
                if (expected_reports.size() == 0)
                begin
                    $error("result transfer with none expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("format_tag", 32'(want.format_tag), 32'(got.format_tag));
                    check_field("channel_count", 32'(want.channel_count),
                                32'(got.channel_count));
                    check_field("sample_rate_hz", want.sample_rate_hz, got.sample_rate_hz);
                    check_field("sample_bits", 32'(want.sample_bits), 32'(got.sample_bits));
                    check_field("payload_offset", want.payload_offset, got.payload_offset);
                    check_field("payload_length", want.payload_length, got.payload_length);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    initial
    begin
        clear_parse();
        send_gap_pct   = 32;
        recv_stall_pct = 65;
        directed_files();
        random_files(300);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0) @(posedge clk);
        send_gap_pct   = 65;
        recv_stall_pct = 32;
        random_files(300);

        while (pending_bytes.size() != 0) @(posedge clk);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        random_files(300);

        while (pending_bytes.size() != 0 || s_tvalid) @(posedge clk);
        while (expected_reports.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
